// ----- rtl/spadd_pkg.sv -----
// shared types and constants of the sparse polynomial adder
// used by every file of the block, no dependencies
`default_nettype none

package spadd_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int EXP_BITS    = 16;

  localparam int OP_W        = 2;
  localparam int COEF_W      = 32;
  localparam int SUM_W       = COEF_W + 1;
  localparam int EXP_FIELD_W = 16;

  // exponent bits that are kept in the stores
  localparam int STORE_EXP_W = (EXP_BITS < EXP_FIELD_W) ? EXP_BITS : EXP_FIELD_W;
  // term count runs 0..MAX_TERMS, address 0..MAX_TERMS-1
  localparam int CNT_W       = $clog2(MAX_TERMS + 1);
  localparam int ADDR_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_ADD    = 2'd2
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start_add;
    logic emit_term;
    logic emit_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic counts_zero;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/spadd_if.sv -----
// valid/ready channel interfaces for input items and result items
// depends on spadd_pkg for field widths
`default_nettype none

interface spadd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [spadd_pkg::OP_W-1:0]            operation;
  logic signed [spadd_pkg::COEF_W-1:0]   coefficient;
  logic [spadd_pkg::EXP_FIELD_W-1:0]     exponent;

  modport source (output valid, output operation, output coefficient, output exponent,
                  input ready);
  modport sink   (input valid, input operation, input coefficient, input exponent,
                  output ready);
endinterface

interface spadd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spadd_pkg::SUM_W-1:0]    sum_coefficient;
  logic [spadd_pkg::EXP_FIELD_W-1:0]     sum_exponent;
  logic                                  last_term;
  logic                                  result_empty;
  logic                                  overflowed;

  modport source (output valid, output sum_coefficient, output sum_exponent,
                  output last_term, output result_empty, output overflowed,
                  input ready);
  modport sink   (input valid, input sum_coefficient, input sum_exponent,
                  input last_term, input result_empty, input overflowed,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/sparse_polynomial_add_merge.sv -----
// top level of the sparse polynomial adder: controller plus datapath
// depends on spadd_pkg, spadd_if, spadd_ctrl and spadd_dp
//
// channel   dir  handshake     payload
// in_i      in   valid/ready   operation, coefficient, exponent
// out_o     out  valid/ready   sum_coefficient, sum_exponent, last_term,
//                              result_empty, overflowed
//
// a load item is taken while idle; an add is accepted, then each result term takes
// a registered store read, then a compare and add; an add on two empty stores is
// accepted and then gives the empty result
// reset clears term counts, merge indices, overflow flag, output valid and controller;
// store contents undefined; a stalled result holds the merge; no item is taken while an add is running
`default_nettype none

module sparse_polynomial_add_merge (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  spadd_in_if.sink      in_i,
  spadd_out_if.source   out_o
);

  spadd_pkg::cmd_t    cmd;
  spadd_pkg::status_t status;
  logic               in_ready;

  assign in_i.ready = in_ready;

  spadd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  spadd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .coefficient_i     (in_i.coefficient),
    .exponent_i        (in_i.exponent),
    .out_ready_i       (out_o.ready),
    .status_o          (status),
    .out_valid_o       (out_o.valid),
    .sum_coefficient_o (out_o.sum_coefficient),
    .sum_exponent_o    (out_o.sum_exponent),
    .last_term_o       (out_o.last_term),
    .result_empty_o    (out_o.result_empty),
    .overflowed_o      (out_o.overflowed)
  );

endmodule

`default_nettype wire

// ----- rtl/spadd_ctrl.sv -----
// controller state machine: decodes input items and sequences the merge
// depends on spadd_pkg (op codes, command and status structs)
`default_nettype none

module spadd_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [spadd_pkg::OP_W-1:0] operation_i,
  input  wire spadd_pkg::status_t         status_i,
  output logic                            in_ready_o,
  output spadd_pkg::cmd_t                 cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_EMPTY
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (spadd_pkg::op_e'(operation_i))
            spadd_pkg::OP_LOAD_A: cmd_o.load_a = 1'b1;
            spadd_pkg::OP_LOAD_B: cmd_o.load_b = 1'b1;
            spadd_pkg::OP_ADD: begin
              if (status_i.counts_zero) begin
                state_d = ST_EMPTY;
              end else begin
                cmd_o.start_add = 1'b1;
                state_d         = ST_READ;
              end
            end
            default: ;  // unused code, item is dropped
          endcase
        end
      end
      // store heads are being read
      ST_READ: state_d = ST_MERGE;
      ST_MERGE: begin
        if (status_i.out_free) begin
          cmd_o.emit_term = 1'b1;
          state_d         = status_i.last ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/spadd_dp.sv -----
// datapath: term stores, counts, merge compare and add, result register
// depends on spadd_pkg (widths, command and status structs)
`default_nettype none

module spadd_dp (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire spadd_pkg::cmd_t                          cmd_i,
  input  wire logic signed [spadd_pkg::COEF_W-1:0]      coefficient_i,
  input  wire logic [spadd_pkg::EXP_FIELD_W-1:0]        exponent_i,
  input  wire logic                                     out_ready_i,
  output spadd_pkg::status_t                            status_o,
  output logic                                          out_valid_o,
  output logic signed [spadd_pkg::SUM_W-1:0]            sum_coefficient_o,
  output logic [spadd_pkg::EXP_FIELD_W-1:0]             sum_exponent_o,
  output logic                                          last_term_o,
  output logic                                          result_empty_o,
  output logic                                          overflowed_o
);

  localparam int CNT_W  = spadd_pkg::CNT_W;
  localparam int ADDR_W = spadd_pkg::ADDR_W;
  localparam int SEW    = spadd_pkg::STORE_EXP_W;
  localparam int CW     = spadd_pkg::COEF_W;
  localparam int SW     = spadd_pkg::SUM_W;
  localparam int EW     = spadd_pkg::EXP_FIELD_W;
  localparam int MT     = spadd_pkg::MAX_TERMS;

  logic signed [CW-1:0] a_coef_mem [MT];
  logic [SEW-1:0]       a_exp_mem  [MT];
  logic signed [CW-1:0] b_coef_mem [MT];
  logic [SEW-1:0]       b_exp_mem  [MT];

  logic signed [CW-1:0] rd_a_coef_q, rd_b_coef_q;
  logic [SEW-1:0]       rd_a_exp_q, rd_b_exp_q;

  logic [CNT_W-1:0] cnt_a_q, cnt_b_q, ia_q, ib_q;
  logic             ovf_q;

  logic             out_valid_q;
  logic signed [SW-1:0] sum_coef_q;
  logic [EW-1:0]    sum_exp_q;
  logic             last_q, empty_q, ovf_out_q;

  logic a_full, b_full, a_has, b_has, take_a, take_b, last;
  logic [CNT_W-1:0] ia_nx, ib_nx;
  logic signed [SW-1:0] term_coef;
  logic [SEW-1:0]   term_exp;
  logic             out_free, clear;

  assign a_full = (cnt_a_q >= CNT_W'(MT));
  assign b_full = (cnt_b_q >= CNT_W'(MT));
  assign a_has  = (ia_q < cnt_a_q);
  assign b_has  = (ib_q < cnt_b_q);

  // pick the higher exponent, both heads on a tie
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (a_has && b_has) begin
      if (rd_a_exp_q == rd_b_exp_q) begin
        take_a = 1'b1;
        take_b = 1'b1;
      end else if (rd_a_exp_q > rd_b_exp_q) begin
        take_a = 1'b1;
      end else begin
        take_b = 1'b1;
      end
    end else if (a_has) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
  end

  always_comb begin
    if (take_a && take_b) begin
      term_coef = SW'(rd_a_coef_q) + SW'(rd_b_coef_q);
    end else if (take_a) begin
      term_coef = SW'(rd_a_coef_q);
    end else begin
      term_coef = SW'(rd_b_coef_q);
    end
    term_exp = take_a ? rd_a_exp_q : rd_b_exp_q;
  end

  assign ia_nx    = ia_q + CNT_W'(take_a);
  assign ib_nx    = ib_q + CNT_W'(take_b);
  assign last     = (ia_nx >= cnt_a_q) && (ib_nx >= cnt_b_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign clear    = (cmd_i.emit_term && last) || cmd_i.emit_empty;

  assign status_o.out_free    = out_free;
  assign status_o.counts_zero = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign status_o.last        = last;

  // stores: one write port each, registered read at the merge index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !a_full) begin
      a_coef_mem[cnt_a_q[ADDR_W-1:0]] <= coefficient_i;
      a_exp_mem[cnt_a_q[ADDR_W-1:0]]  <= exponent_i[SEW-1:0];
    end
    if (cmd_i.load_b && !b_full) begin
      b_coef_mem[cnt_b_q[ADDR_W-1:0]] <= coefficient_i;
      b_exp_mem[cnt_b_q[ADDR_W-1:0]]  <= exponent_i[SEW-1:0];
    end
    rd_a_coef_q <= a_coef_mem[ia_q[ADDR_W-1:0]];
    rd_a_exp_q  <= a_exp_mem[ia_q[ADDR_W-1:0]];
    rd_b_coef_q <= b_coef_mem[ib_q[ADDR_W-1:0]];
    rd_b_exp_q  <= b_exp_mem[ib_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_a) begin
        if (a_full) ovf_q <= 1'b1;
        else        cnt_a_q <= cnt_a_q + CNT_W'(1);
      end
      if (cmd_i.load_b) begin
        if (b_full) ovf_q <= 1'b1;
        else        cnt_b_q <= cnt_b_q + CNT_W'(1);
      end
      if (cmd_i.start_add) begin
        ia_q <= '0;
        ib_q <= '0;
      end else if (cmd_i.emit_term) begin
        ia_q <= ia_nx;
        ib_q <= ib_nx;
      end
      if (clear) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.emit_term || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_term) begin
      sum_coef_q <= term_coef;
      sum_exp_q  <= EW'(term_exp);
      last_q     <= last;
      empty_q    <= 1'b0;
      ovf_out_q  <= ovf_q;
    end else if (cmd_i.emit_empty) begin
      sum_coef_q <= '0;
      sum_exp_q  <= '0;
      last_q     <= 1'b1;
      empty_q    <= 1'b1;
      ovf_out_q  <= ovf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sum_coefficient_o = sum_coef_q;
  assign sum_exponent_o    = sum_exp_q;
  assign last_term_o       = last_q;
  assign result_empty_o    = empty_q;
  assign overflowed_o      = ovf_out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CNT_W'(MT)) && (cnt_b_q <= CNT_W'(MT)))
    else $error("term count beyond store depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_term || cmd_i.emit_empty) |-> out_free)
    else $error("result written over a pending item");

  a_emit_has_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_term |-> (a_has || b_has))
    else $error("merge step with both stores exhausted");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q)
    else $error("stores not cleared after add");

endmodule

`default_nettype wire
